@@ rtl/adcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_pkg
// Shared types and constants for the converter scan sequencer.
// ----------------------------------------------------------------------------
package adcs_pkg;

    // Field widths.
    localparam int CHAN_W   = 5;
    localparam int SAMPLE_W = 12;
    localparam int KIND_W   = 3;
    localparam int PIXIDX_W = 7;
    localparam int CFG_IDX_W = 3;

    // Input item kinds.
    localparam logic FUNC_FRAME_TICK = 1'b0;
    localparam logic FUNC_CONV_DONE  = 1'b1;

    // Sample labels.
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POT0    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POT1    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BATTERY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POT0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POT1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATTERY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA1 = 3'd4;

    // Configuration reset values.
    localparam logic [CHAN_W-1:0] RST_POT0    = 5'd13;
    localparam logic [CHAN_W-1:0] RST_POT1    = 5'd12;
    localparam logic [CHAN_W-1:0] RST_BATTERY = 5'd4;
    localparam logic [CHAN_W-1:0] RST_CAMERA0 = 5'd6;
    localparam logic [CHAN_W-1:0] RST_CAMERA1 = 5'd7;

    // Channel numbers as seen by the sequencer.
    typedef struct packed {
        logic [CHAN_W-1:0] pot0;
        logic [CHAN_W-1:0] pot1;
        logic [CHAN_W-1:0] battery;
        logic [CHAN_W-1:0] camera0;
        logic [CHAN_W-1:0] camera1;
    } chan_cfg_t;

    // One result item.
    typedef struct packed {
        logic                start_conversion;
        logic [CHAN_W-1:0]   next_channel;
        logic                mux_side_b;
        logic                start_pulse_level;
        logic                cam_clock_level;
        logic                cam_clock_pulse;
        logic [KIND_W-1:0]   sample_kind;
        logic [SAMPLE_W-1:0] captured_value;
        logic                pixel_camera;
        logic [PIXIDX_W-1:0] pixel_index;
        logic                pixel_bank;
        logic                frame_ready;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/adcs_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_cfg
// Channel number registers, written through a plain write port.
// ----------------------------------------------------------------------------
module adcs_cfg
    import adcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [CHAN_W-1:0]    wr_data,
    output chan_cfg_t                 chan_cfg
);

    chan_cfg_t cfg_reg;

    // Register writes; indexes outside the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pot0    <= RST_POT0;
            cfg_reg.pot1    <= RST_POT1;
            cfg_reg.battery <= RST_BATTERY;
            cfg_reg.camera0 <= RST_CAMERA0;
            cfg_reg.camera1 <= RST_CAMERA1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_POT0:    cfg_reg.pot0    <= wr_data;
                REG_POT1:    cfg_reg.pot1    <= wr_data;
                REG_BATTERY: cfg_reg.battery <= wr_data;
                REG_CAMERA0: cfg_reg.camera0 <= wr_data;
                REG_CAMERA1: cfg_reg.camera1 <= wr_data;
                default:     ;
            endcase
        end
    end

    assign chan_cfg = cfg_reg;

endmodule
`default_nettype wire

@@ rtl/adcs_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_seq
// Scan state machine: labels each finished sample, picks the next channel
// and drives the camera start and clock line levels.
// ----------------------------------------------------------------------------
module adcs_seq
    import adcs_pkg::*;
#(
    parameter int PIXELS_PER_LINE = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire logic                func,
    input  wire logic [SAMPLE_W-1:0] sample_value,
    input  wire chan_cfg_t           chan_cfg,
    output result_t                  result
);

    localparam int CNT_W = $clog2(PIXELS_PER_LINE + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS_PER_LINE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_POT0 = 3'd1,
        ST_POT1 = 3'd2,
        ST_BATT = 3'd3,
        ST_LINE = 3'd4
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic             cam_sel_reg, cam_sel_next;
    logic             bank_reg, bank_next;
    logic             start_line_reg, start_line_next;
    logic             clock_line_reg, clock_line_next;
    result_t          res;

    // Next state and result for the item on the input.
    always_comb
    begin
        state_next      = state_reg;
        pix_cnt_next    = pix_cnt_reg;
        cam_sel_next    = cam_sel_reg;
        bank_next       = bank_reg;
        start_line_next = start_line_reg;
        clock_line_next = clock_line_reg;
        res             = '0;

        if (func == FUNC_FRAME_TICK)
        begin
            // A frame tick restarts at the first potentiometer.
            start_line_next      = 1'b1;
            state_next           = ST_POT0;
            res.start_conversion = 1'b1;
            res.next_channel     = chan_cfg.pot0;
        end
        else
        begin
            case (state_reg)
                ST_POT0:
                begin
                    res.sample_kind      = KIND_POT0;
                    res.captured_value   = sample_value;
                    res.start_conversion = 1'b1;
                    res.next_channel     = chan_cfg.pot1;
                    state_next           = ST_POT1;
                end
                ST_POT1:
                begin
                    res.sample_kind      = KIND_POT1;
                    res.captured_value   = sample_value;
                    res.start_conversion = 1'b1;
                    res.next_channel     = chan_cfg.battery;
                    res.mux_side_b       = 1'b1;
                    state_next           = ST_BATT;
                end
                ST_BATT:
                begin
                    res.sample_kind      = KIND_BATTERY;
                    res.captured_value   = sample_value;
                    clock_line_next      = 1'b1;
                    start_line_next      = 1'b0;
                    pix_cnt_next         = '0;
                    cam_sel_next         = 1'b0;
                    state_next           = ST_LINE;
                    res.start_conversion = 1'b1;
                    res.next_channel     = chan_cfg.camera0;
                    res.mux_side_b       = 1'b1;
                end
                ST_LINE:
                begin
                    if (pix_cnt_reg < LAST_CNT)
                    begin
                        res.sample_kind      = KIND_PIXEL;
                        res.captured_value   = sample_value;
                        res.pixel_index      = PIXIDX_W'(pix_cnt_reg);
                        res.pixel_bank       = bank_reg;
                        res.start_conversion = 1'b1;
                        res.mux_side_b       = 1'b1;
                        if (!cam_sel_reg)
                        begin
                            res.next_channel = chan_cfg.camera1;
                            cam_sel_next     = 1'b1;
                        end
                        else
                        begin
                            // Second pixel of a pair: advance and pulse the clock.
                            res.pixel_camera    = 1'b1;
                            res.next_channel    = chan_cfg.camera0;
                            cam_sel_next        = 1'b0;
                            pix_cnt_next        = CNT_W'(pix_cnt_reg + 1'b1);
                            res.cam_clock_pulse = 1'b1;
                            clock_line_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        // Trailing conversion: end the line and swap banks.
                        res.cam_clock_pulse = 1'b1;
                        clock_line_next     = 1'b0;
                        state_next          = ST_IDLE;
                        bank_next           = ~bank_reg;
                        res.frame_ready     = 1'b1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        res.start_pulse_level = start_line_next;
        res.cam_clock_level   = clock_line_next;
    end

    // State registers advance only when an item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pix_cnt_reg    <= '0;
            cam_sel_reg    <= 1'b0;
            bank_reg       <= 1'b0;
            start_line_reg <= 1'b0;
            clock_line_reg <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg      <= state_next;
            pix_cnt_reg    <= pix_cnt_next;
            cam_sel_reg    <= cam_sel_next;
            bank_reg       <= bank_next;
            start_line_reg <= start_line_next;
            clock_line_reg <= clock_line_next;
        end
    end

    assign result = res;

endmodule
`default_nettype wire

@@ rtl/adc_scan_linescan_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adc_scan_linescan_sequencer
// Sequences converter channels for pots, battery sense and two line-scan
// cameras, and labels each finished sample.
// The result of an accepted event is registered and is on the output in the cycle after it is taken.
// Throughput: one event per cycle while the result stream is not stalled; the
// state machine decides each event combinationally and the result register frees as soon as it is taken.
// Reset: state idle, counters and lines low, channel registers to defaults,
// output empty.
// ----------------------------------------------------------------------------
module adc_scan_linescan_sequencer
    import adcs_pkg::*;
#(
    parameter int PIXELS_PER_LINE = 128
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Event stream.
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [15:0]          s_tdata,  // [11:0] sample_value, rest zero
    input  wire logic                 s_tuser,  // [0] func
    // Result stream.
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [0] start_conversion, [5:1] next_channel, [6] mux_side_b,
    // [7] start_pulse_level, [8] cam_clock_level, [9] cam_clock_pulse,
    // [21:10] captured_value, [22] pixel_camera, [29:23] pixel_index,
    // [30] pixel_bank, [31] frame_ready
    output      logic [31:0]          m_tdata,
    output      logic [KIND_W-1:0]    m_tuser,  // [2:0] sample_kind
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CHAN_W-1:0]    cfg_data
);

    chan_cfg_t chan_cfg;
    result_t   step_res;
    result_t   res_reg;
    logic      out_valid_reg;
    logic      accept;

    adcs_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .chan_cfg (chan_cfg)
    );

    // The result register can take a new item when empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    adcs_seq #(
        .PIXELS_PER_LINE (PIXELS_PER_LINE)
    ) u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (accept),
        .func         (s_tuser),
        .sample_value (s_tdata[SAMPLE_W-1:0]),
        .chan_cfg     (chan_cfg),
        .result       (step_res)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.sample_kind;
    assign m_tdata  = {res_reg.frame_ready,
                       res_reg.pixel_bank,
                       res_reg.pixel_index,
                       res_reg.pixel_camera,
                       res_reg.captured_value,
                       res_reg.cam_clock_pulse,
                       res_reg.cam_clock_level,
                       res_reg.start_pulse_level,
                       res_reg.mux_side_b,
                       res_reg.next_channel,
                       res_reg.start_conversion};

endmodule
`default_nettype wire
